// File: sv/token_grant_table_with_aging_defines.svh
// assertion macros for the grant table checker
// no dependencies; included by the checker file
`ifndef TOKEN_GRANT_TABLE_WITH_AGING_DEFINES_SVH
`define TOKEN_GRANT_TABLE_WITH_AGING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TGT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grant table check failed");

// next-cycle implication, disabled during reset
`define TGT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grant table check failed");

`endif

// File: sv/tgt_pkg.sv
// types, codes and constants for the grant table
// used by every module of the block and by the checker
`timescale 1ns / 1ps

package tgt_pkg;

	localparam int FUNC_W       = 3;
	localparam int USER_W       = 32;
	localparam int TOKEN_W      = 64;
	localparam int LIFE_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int DEPTH_DEF    = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;
	localparam logic [LIFE_W-1:0]  LIFETIME_RST = 32'd30000;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_VERIFY = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_REVOKE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [USER_W-1:0]  user_id;
		logic [TOKEN_W-1:0] token_value;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [COUNT_W-1:0] live_count;
	} rsp_t;

	// pass marker handed from cell to cell
	typedef struct packed {
		logic               go;
		logic               found;
		logic [COUNT_W-1:0] count;
	} link_t;

endpackage

// File: sv/tgt_cell.sv
// one table slot: holds a grant and applies the current request when the pass reaches it
// depends on tgt_pkg
`timescale 1ns / 1ps

module tgt_cell import tgt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [FUNC_W-1:0]  func,
	input  logic [USER_W-1:0]  user_id,
	input  logic [TOKEN_W-1:0] token_value,
	input  logic [LIFE_W-1:0]  lifetime,
	input  link_t              link_in,
	output link_t              link_out
);

	logic               valid_q;
	logic [USER_W-1:0]  user_q;
	logic [TOKEN_W-1:0] token_q;
	logic [LIFE_W-1:0]  remain_q;

	logic               valid_d;
	logic               load;
	logic               refresh;
	logic               decr;
	logic               found_d;
	logic               user_hit;
	link_t              link_d;

	assign user_hit = valid_q && (user_q == user_id);

	// slot update for the request passing through
	always_comb begin
		valid_d = valid_q;
		load    = 1'b0;
		refresh = 1'b0;
		decr    = 1'b0;
		found_d = link_in.found;
		case (func)
			FUNC_ADD: begin
				if (!link_in.found && !valid_q) begin
					valid_d = 1'b1;
					load    = 1'b1;
					found_d = 1'b1;
				end
			end
			FUNC_VERIFY: begin
				if (!link_in.found && user_hit && (token_q == token_value)) begin
					refresh = 1'b1;
					found_d = 1'b1;
				end
			end
			FUNC_REVOKE: begin
				if (user_hit)
					valid_d = 1'b0;
			end
			FUNC_TICK: begin
				if (valid_q) begin
					if (remain_q == '0)
						valid_d = 1'b0;
					else
						decr = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				valid_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// running count of live slots, saturating
	always_comb begin
		link_d.go    = link_in.go;
		link_d.found = found_d;
		if (valid_d && (link_in.count != COUNT_MAX))
			link_d.count = link_in.count + COUNT_W'(1);
		else
			link_d.count = link_in.count;
	end

	// slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (link_in.go) begin
			valid_q <= valid_d;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (link_in.go) begin
			if (load) begin
				user_q   <= user_id;
				token_q  <= token_value;
				remain_q <= lifetime;
			end else if (refresh) begin
				remain_q <= lifetime;
			end else if (decr) begin
				remain_q <= remain_q - LIFE_W'(1);
			end
		end
	end

	// hand the pass to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_out <= '0;
		end else begin
			link_out <= link_d;
		end
	end

endmodule

// File: sv/token_grant_table_with_aging.sv
// grant table with aging: top level, request control and response buffering
// depends on tgt_pkg and tgt_cell
//
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_t (func, user_id, token_value)
// rsp       out  rsp_valid/rsp_ready    rsp_t (success, live_count)
// cfg       in   cfg_valid/cfg_ready    cfg_data (lifetime_ticks)
//
// a request passes the row of cells one slot per cycle; the response is registered
// at the end of the row, one request at a time.
// the next request is taken once the pass ends, even while the response waits.
// reset empties the table and loads lifetime_ticks with 30000.
// req_ready is low during a pass; a stalled response moves to a spare register,
// and req_ready also stays low while both hold a response.
`timescale 1ns / 1ps

module token_grant_table_with_aging import tgt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LIFE_W-1:0] cfg_data
);

	logic [LIFE_W-1:0] lifetime_q;
	req_t              req_q;
	logic              busy_q;
	logic              start_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              hold_valid_q;
	rsp_t              hold_q;

	link_t             chain [TABLE_DEPTH+1];
	logic              req_fire;
	logic              done;
	logic              out_free;
	rsp_t              result;

	assign req_ready = !busy_q && !hold_valid_q;
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;

	// lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			lifetime_q <= cfg_data;
		end
	end

	// request capture, broadcast to all cells during the pass
	always_ff @(posedge clk) begin
		if (req_fire)
			req_q <= req;
	end

	// pass control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= req_fire;
			if (req_fire)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;
		end
	end

	// row of cells
	assign chain[0].go    = start_q;
	assign chain[0].found = 1'b0;
	assign chain[0].count = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tgt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.func        (req_q.func),
			.user_id     (req_q.user_id),
			.token_value (req_q.token_value),
			.lifetime    (lifetime_q),
			.link_in     (chain[i]),
			.link_out    (chain[i+1])
		);
	end

	// response from the end of the row
	assign done              = chain[TABLE_DEPTH].go;
	assign result.success    = ((req_q.func == FUNC_ADD) || (req_q.func == FUNC_VERIFY)) ?
	                           chain[TABLE_DEPTH].found : 1'b1;
	assign result.live_count = chain[TABLE_DEPTH].count;
	assign out_free          = !rsp_valid_q || rsp_ready;

	// output register with a spare slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (hold_valid_q && out_free) begin
				rsp_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (done) begin
				if (out_free)
					rsp_valid_q <= 1'b1;
				else
					hold_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_valid_q && out_free) begin
			rsp_q <= hold_q;
		end else if (done) begin
			if (out_free)
				rsp_q <= result;
			else
				hold_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/tgt_checker.sv
// port-level checks for the grant table, attached to the top level by bind
// depends on tgt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "token_grant_table_with_aging_defines.svh"

module tgt_checker import tgt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input req_t              req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rsp_t              rsp,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [LIFE_W-1:0] cfg_data
);

	localparam logic [COUNT_W-1:0] CNT_BOUND =
		(TABLE_DEPTH > 31) ? COUNT_MAX : COUNT_W'(TABLE_DEPTH);

	// count never exceeds the number of slots
	`TGT_ASSERT_NOW(a_count_bound, rsp_valid, rsp.live_count <= CNT_BOUND)

	// one request at a time: ready drops right after a request is taken
	`TGT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	// a stalled response holds
	`TGT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// the lifetime register always takes writes
	`TGT_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind token_grant_table_with_aging tgt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tgt_checker (.*);
